>>> hw/rtl/bsm_pkg.sv
// Package for the button sequence matcher.
// Holds item, kind and status codes used by the front and back parts.
// No dependencies.
package bsm_pkg;

  localparam int DEF_CHANNELS    = 4;
  localparam int DEF_PATTERNS    = 16;
  localparam int DEF_PATTERN_LEN = 16;

  localparam logic [3:0]  WILDCARD      = 4'd9;
  localparam logic [16:0] TIMER_MAX     = 17'h1FFFF;
  localparam logic [15:0] RST_TIMEOUT   = 16'd1000;

  localparam logic [2:0] FN_PRESS  = 3'd0;
  localparam logic [2:0] FN_TICK   = 3'd1;
  localparam logic [2:0] FN_SYMBOL = 3'd2;
  localparam logic [2:0] FN_ATTR   = 3'd3;
  localparam logic [2:0] FN_CLEAR  = 3'd4;

  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_DETECT  = 2'd1;
  localparam logic [1:0] ST_REJECT  = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  localparam logic [1:0] CFG_ENABLE  = 2'd0;
  localparam logic [1:0] CFG_COUNT   = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT = 2'd2;

  typedef enum logic [2:0] {
    K_PRESS,
    K_TICK,
    K_SYMBOL,
    K_ATTR,
    K_CLEAR,
    K_BAD
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic        ok;
    logic [1:0]  channel;
    logic [3:0]  button;
    logic        pressed;
    logic [15:0] delta;
    logic [3:0]  slot;
    logic [3:0]  pos;
    logic [15:0] ptime;
    logic        pen;
    logic        all;
  } item_t;

endpackage

>>> hw/rtl/bsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/bsm_front.sv
// Front part: accepts input words, classifies them and queues them.
// Depends on bsm_pkg.
module bsm_front #(
  parameter int PATTERNS    = bsm_pkg::DEF_PATTERNS,
  parameter int PATTERN_LEN = bsm_pkg::DEF_PATTERN_LEN
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [2:0]    func,
  input  logic [1:0]    channel,
  input  logic [3:0]    button,
  input  logic          pressed,
  input  logic [15:0]   elapsed_ms,
  input  logic [3:0]    pattern_slot,
  input  logic [3:0]    position,
  input  logic [15:0]   pattern_timeout,
  input  logic          pattern_enable,
  input  logic          all_channels,
  output logic          q_valid,
  output bsm_pkg::item_t q_item,
  input  logic          q_pop
);
  import bsm_pkg::*;

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  item_t      cls;
  logic       push;
  logic       slot_ok;
  logic       pos_ok;

  assign slot_ok = 7'(pattern_slot) < 7'(PATTERNS);
  assign pos_ok  = 7'(position) < 7'(PATTERN_LEN);

  always_comb begin
    cls.channel = channel;
    cls.button  = button;
    cls.pressed = pressed;
    cls.delta   = elapsed_ms;
    cls.slot    = pattern_slot;
    cls.pos     = position;
    cls.ptime   = pattern_timeout;
    cls.pen     = pattern_enable;
    cls.all     = all_channels;
    cls.ok      = 1'b1;
    unique case (func)
      FN_PRESS:  cls.kind = K_PRESS;
      FN_TICK:   cls.kind = K_TICK;
      FN_SYMBOL: begin
        cls.kind = K_SYMBOL;
        cls.ok   = slot_ok && pos_ok;
      end
      FN_ATTR: begin
        cls.kind = K_ATTR;
        cls.ok   = slot_ok;
      end
      FN_CLEAR:  cls.kind = K_CLEAR;
      default:   cls.kind = K_BAD;
    endcase
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cls;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

>>> hw/rtl/bsm_back.sv
// Back part: executes queued words against pattern table and channel state.
// Depends on bsm_pkg and bsm_ram.
module bsm_back #(
  parameter int CHANNELS    = bsm_pkg::DEF_CHANNELS,
  parameter int PATTERNS    = bsm_pkg::DEF_PATTERNS,
  parameter int PATTERN_LEN = bsm_pkg::DEF_PATTERN_LEN
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  bsm_pkg::item_t q_item,
  output logic           q_pop,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_data,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [1:0]     status,
  output logic [3:0]     matched_pattern,
  output logic [3:0]     history_length,
  output logic [3:0]     timeout_mask
);
  import bsm_pkg::*;

  localparam int ROW_W = PATTERN_LEN * 4;
  localparam int ENT_W = ROW_W + 17;
  localparam int AW    = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
  localparam int NW    = $clog2(PATTERNS + 1);
  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int LW    = $clog2(PATTERN_LEN);
  localparam logic [LW-1:0] HIST_MAX = LW'(PATTERN_LEN - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_MERGE = 5'b00100,
    S_TICK  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t            state;
  item_t             cur;
  logic              detect_enable;
  logic [4:0]        slot_count;
  logic [15:0]       default_timeout;
  logic [ROW_W-1:0]  hist_row [CHANNELS];
  logic [LW-1:0]     hist_len [CHANNELS];
  logic [16:0]       idle_timer [CHANNELS];
  logic [PATTERNS-1:0] row_valid;
  logic [NW-1:0]     issue_cnt;
  logic [NW-1:0]     lim;
  logic              pipe_v;
  logic [AW-1:0]     pipe_idx;
  logic              rd_valid;
  logic [15:0]       best;
  logic [1:0]        res_status;
  logic [3:0]        res_match;
  logic [3:0]        res_mask;

  logic [NW-1:0]     lim_w;
  logic [CW-1:0]     q_ch;
  logic              q_ch_ok;
  logic [CW-1:0]     ch_idx;
  logic              ch_ok;
  logic [AW-1:0]     raddr;
  logic [ENT_W-1:0]  rdata;
  logic [ENT_W-1:0]  row;
  logic              we;
  logic [ENT_W-1:0]  wdata;
  logic [ROW_W-1:0]  hrow;
  logic [LW-1:0]     hlen;
  logic [PATTERN_LEN-1:0] pos_hit;
  logic              hit;
  logic              last;
  logic              out_load;
  logic [ROW_W-1:0]  merged_sym;

  assign cfg_ready = 1'b1;
  assign lim_w = (7'(slot_count) > 7'(PATTERNS)) ? NW'(PATTERNS) : NW'(slot_count);
  assign q_ch    = CW'(q_item.channel);
  assign q_ch_ok = 5'(q_item.channel) < 5'(CHANNELS);
  assign ch_idx  = CW'(cur.channel);
  assign ch_ok   = 5'(cur.channel) < 5'(CHANNELS);
  assign q_pop   = (state == S_IDLE) && q_valid;

  assign raddr = (state == S_IDLE) ? AW'(q_item.slot) : issue_cnt[AW-1:0];
  assign row   = rd_valid ? rdata : '0;
  assign hrow  = hist_row[ch_idx];
  assign hlen  = hist_len[ch_idx];
  assign last  = (NW'(pipe_idx) == lim - NW'(1));

  always_comb begin
    for (int j = 0; j < PATTERN_LEN; j++) begin
      if (LW'(j) < hlen || j > int'(HIST_MAX)) begin
        pos_hit[j] = (j > int'(HIST_MAX)) ? (row[4*j +: 4] == 4'd0) :
                     (row[4*j +: 4] != 4'd0) &&
                     (row[4*j +: 4] == WILDCARD || row[4*j +: 4] == hrow[4*j +: 4]);
      end else if (LW'(j) == hlen) begin
        pos_hit[j] = (row[4*j +: 4] == 4'd0);
      end else begin
        pos_hit[j] = 1'b1;
      end
    end
    hit = &pos_hit;
  end

  always_comb begin
    merged_sym = row[ROW_W-1:0];
    for (int j = 0; j < PATTERN_LEN; j++) begin
      if (cur.pos == 4'(j)) begin
        merged_sym[4*j +: 4] = cur.button;
      end
    end
    we = (state == S_MERGE);
    if (cur.kind == K_ATTR) begin
      wdata = {cur.pen, cur.ptime, row[ROW_W-1:0]};
    end else begin
      wdata = {row[ENT_W-1:ROW_W], merged_sym};
    end
  end

  bsm_ram #(.WIDTH(ENT_W), .DEPTH(PATTERNS), .AW(AW)) u_rows (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(cur.slot)),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    rd_valid <= row_valid[raddr];
    if (out_load) begin
      status          <= res_status;
      matched_pattern <= res_match;
      timeout_mask    <= res_mask;
      history_length  <= ch_ok ? 4'(hist_len[ch_idx]) : 4'd0;
    end
    if (rst) begin
      state           <= S_IDLE;
      detect_enable   <= 1'b1;
      slot_count      <= 5'd0;
      default_timeout <= RST_TIMEOUT;
      row_valid       <= '0;
      out_valid       <= 1'b0;
      pipe_v          <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        hist_len[c]   <= '0;
        idle_timer[c] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_ENABLE:  detect_enable   <= cfg_data[0];
          CFG_COUNT:   slot_count      <= cfg_data[4:0];
          CFG_TIMEOUT: default_timeout <= cfg_data;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur        <= q_item;
            res_status <= ST_NONE;
            res_match  <= 4'd0;
            res_mask   <= 4'd0;
            issue_cnt  <= '0;
            lim        <= lim_w;
            pipe_v     <= 1'b0;
            best       <= default_timeout;
            state      <= S_OUT;
            unique case (q_item.kind)
              K_PRESS: begin
                if (!detect_enable || !q_ch_ok || !q_item.pressed) begin
                  res_status <= ST_REJECT;
                end else begin
                  if (hist_len[q_ch] < HIST_MAX) begin
                    for (int j = 0; j < PATTERN_LEN; j++) begin
                      if (hist_len[q_ch] == LW'(j)) begin
                        hist_row[q_ch][4*j +: 4] <= q_item.button;
                      end
                    end
                    hist_len[q_ch]   <= hist_len[q_ch] + LW'(1);
                    idle_timer[q_ch] <= '0;
                  end
                  if (lim_w != '0) begin
                    state <= S_SCAN;
                  end
                end
              end
              K_TICK: state <= (lim_w != '0) ? S_SCAN : S_TICK;
              K_SYMBOL, K_ATTR: begin
                if (q_item.ok) begin
                  state <= S_MERGE;
                end else begin
                  res_status <= ST_REJECT;
                end
              end
              K_CLEAR: begin
                if (q_item.all) begin
                  for (int c = 0; c < CHANNELS; c++) begin
                    hist_len[c]   <= '0;
                    idle_timer[c] <= '0;
                  end
                end else if (q_ch_ok) begin
                  hist_len[q_ch]   <= '0;
                  idle_timer[q_ch] <= '0;
                end else begin
                  res_status <= ST_REJECT;
                end
              end
              default: res_status <= ST_REJECT;
            endcase
          end
        end
        S_SCAN: begin
          if (issue_cnt < lim) begin
            issue_cnt <= issue_cnt + NW'(1);
            pipe_idx  <= issue_cnt[AW-1:0];
            pipe_v    <= 1'b1;
          end else begin
            pipe_v <= 1'b0;
          end
          if (pipe_v) begin
            if (cur.kind == K_PRESS) begin
              if (row[ENT_W-1] && hit) begin
                res_status       <= ST_DETECT;
                res_match        <= 4'(pipe_idx);
                hist_len[ch_idx] <= '0;
                state            <= S_OUT;
              end else if (last) begin
                state <= S_OUT;
              end
            end else begin
              if (row[ENT_W-1] && row[ROW_W +: 16] > best) begin
                best <= row[ROW_W +: 16];
              end
              if (last) begin
                state <= S_TICK;
              end
            end
          end
        end
        S_MERGE: begin
          row_valid[AW'(cur.slot)] <= 1'b1;
          state <= S_OUT;
        end
        S_TICK: begin
          logic [3:0]  m;
          logic [17:0] t;
          logic [16:0] ts;
          m = 4'd0;
          for (int c = 0; c < CHANNELS; c++) begin
            t  = 18'(idle_timer[c]) + 18'(cur.delta);
            ts = t[17] ? TIMER_MAX : t[16:0];
            if (hist_len[c] != '0) begin
              if (ts > 17'(best)) begin
                hist_len[c]   <= '0;
                idle_timer[c] <= '0;
                if (c < 4) begin
                  m[2'(c)] = 1'b1;
                end
              end else begin
                idle_timer[c] <= ts;
              end
            end
          end
          res_mask   <= m;
          res_status <= (m != 4'd0) ? ST_TIMEOUT : ST_NONE;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/button_sequence_matcher_unit.sv
// Top level of the button sequence matcher.
// Depends on bsm_pkg, bsm_front, bsm_back and bsm_ram.
//
//  channel | handshake          | carries
//  --------+--------------------+--------------------------------------------
//  in      | in_valid/in_stall  | func, channel, button, ... all_channels
//  out     | out_valid/out_stall| status, matched_pattern, history_length,
//          |                    | timeout_mask
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// On an idle block, a tick or an accepted press scans N = min(slot_count,
// PATTERNS) rows of the pattern RAM, one row per cycle; a press stops at a
// hit, a tick then updates the idle timers. Pattern writes pass through a
// merge state. A two-word queue decouples input from execution; the
// output register holds a word under out_stall. Synchronous reset clears
// control state and the pattern row valid bits.
module button_sequence_matcher_unit #(
  parameter int CHANNELS    = bsm_pkg::DEF_CHANNELS,
  parameter int PATTERNS    = bsm_pkg::DEF_PATTERNS,
  parameter int PATTERN_LEN = bsm_pkg::DEF_PATTERN_LEN
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic [1:0]  channel,
  input  logic [3:0]  button,
  input  logic        pressed,
  input  logic [15:0] elapsed_ms,
  input  logic [3:0]  pattern_slot,
  input  logic [3:0]  position,
  input  logic [15:0] pattern_timeout,
  input  logic        pattern_enable,
  input  logic        all_channels,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [3:0]  matched_pattern,
  output logic [3:0]  history_length,
  output logic [3:0]  timeout_mask,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import bsm_pkg::*;

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  bsm_front #(.PATTERNS(PATTERNS), .PATTERN_LEN(PATTERN_LEN)) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .func            (func),
    .channel         (channel),
    .button          (button),
    .pressed         (pressed),
    .elapsed_ms      (elapsed_ms),
    .pattern_slot    (pattern_slot),
    .position        (position),
    .pattern_timeout (pattern_timeout),
    .pattern_enable  (pattern_enable),
    .all_channels    (all_channels),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  bsm_back #(.CHANNELS(CHANNELS), .PATTERNS(PATTERNS), .PATTERN_LEN(PATTERN_LEN)) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .matched_pattern (matched_pattern),
    .history_length  (history_length),
    .timeout_mask    (timeout_mask)
  );

endmodule

>>> tb/sv/button_sequence_matcher_unit_tb.sv
// Testbench for button_sequence_matcher_unit: a directed table, then random
// phases under several register settings and idling mixes, checked against
// typed rows or an in-bench predictor. Depends on bsm_pkg and the RTL.
module button_sequence_matcher_unit_tb;
  import bsm_pkg::*;

  localparam logic [2:0] FN_UNUSED_LO  = 3'd5;
  localparam logic [2:0] FN_UNUSED_MID = 3'd6;
  localparam logic [2:0] FN_UNUSED_HI  = 3'd7;
  localparam int HIST_MAX   = DEF_PATTERN_LEN - 1;
  localparam int DRAIN      = 60;
  localparam int STALL_LIM  = 5000;
  localparam int PHASE_WORDS = 170;

  typedef struct packed {
    logic [2:0]  func;
    logic [1:0]  channel;
    logic [3:0]  button;
    logic        pressed;
    logic [15:0] delta;
    logic [3:0]  slot;
    logic [3:0]  pos;
    logic [15:0] ptime;
    logic        pen;
    logic        all;
  } press_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] matched;
    logic [3:0] hist;
    logic [3:0] mask;
  } match_res_t;

  typedef struct packed {
    press_word_t w;
    logic        typed;
    match_res_t  r;
  } dir_row_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [2:0]  func = '0;
  logic [1:0]  channel = '0;
  logic [3:0]  button = '0;
  logic        pressed = 0;
  logic [15:0] elapsed_ms = '0;
  logic [3:0]  pattern_slot = '0;
  logic [3:0]  position = '0;
  logic [15:0] pattern_timeout = '0;
  logic        pattern_enable = 0;
  logic        all_channels = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [1:0]  status;
  logic [3:0]  matched_pattern;
  logic [3:0]  history_length;
  logic [3:0]  timeout_mask;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  button_sequence_matcher_unit dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [3:0]  h_mem [4][16];
  logic [3:0]  h_len [4];
  logic [16:0] h_tmr [4];
  logic [3:0]  p_sym [16][16];
  logic [15:0] p_tmo [16];
  logic        p_en  [16];
  logic        c_en = 1;
  logic [4:0]  c_cnt = 0;
  logic [15:0] c_dto = RST_TIMEOUT;

  match_res_t result_q[$];
  int errors = 0, n_sent = 0, n_seen = 0, n_detect = 0, n_tmo = 0, quiet = 0;
  int idle_pct = 0, stall_pct = 0;

  initial begin
    for (int c = 0; c < 4; c++) begin
      h_len[c] = 0;
      h_tmr[c] = 0;
      for (int i = 0; i < 16; i++) h_mem[c][i] = 0;
    end
    for (int s = 0; s < 16; s++) begin
      p_tmo[s] = 0;
      p_en[s] = 0;
      for (int i = 0; i < 16; i++) p_sym[s][i] = 0;
    end
  end

  function automatic int scan_lim();
    return (c_cnt > 16) ? 16 : int'(c_cnt);
  endfunction

  function automatic int row_len(int s);
    for (int i = 0; i < 16; i++) if (p_sym[s][i] == 0) return i;
    return 16;
  endfunction

  function automatic logic row_hit(int s, int c);
    if (row_len(s) != int'(h_len[c])) return 0;
    for (int i = 0; i < int'(h_len[c]); i++)
      if (p_sym[s][i] != WILDCARD && p_sym[s][i] != h_mem[c][i]) return 0;
    return 1;
  endfunction

  function automatic match_res_t predict_match(press_word_t w);
    match_res_t r;
    int lim;
    logic [17:0] sum;
    r = '0;
    case (w.func)
      FN_PRESS: begin
        if (!c_en || !w.pressed) begin
          r.status = ST_REJECT;
        end else begin
          if (h_len[w.channel] < HIST_MAX) begin
            h_mem[w.channel][h_len[w.channel]] = w.button;
            h_len[w.channel] = h_len[w.channel] + 4'd1;
            h_tmr[w.channel] = 0;
          end
          for (int s = 0; s < scan_lim() && r.status == ST_NONE; s++)
            if (p_en[s] && row_hit(s, w.channel)) begin
              h_len[w.channel] = 0;
              r.status = ST_DETECT;
              r.matched = 4'(s);
            end
        end
      end
      FN_TICK: begin
        lim = int'(c_dto);
        for (int s = 0; s < scan_lim(); s++)
          if (p_en[s] && int'(p_tmo[s]) > lim) lim = int'(p_tmo[s]);
        for (int c = 0; c < 4; c++)
          if (h_len[c] != 0) begin
            sum = 18'(h_tmr[c]) + 18'(w.delta);
            h_tmr[c] = (sum > 18'(TIMER_MAX)) ? TIMER_MAX : sum[16:0];
            if (int'(h_tmr[c]) > lim) begin
              h_len[c] = 0;
              h_tmr[c] = 0;
              r.mask[c] = 1;
            end
          end
        r.status = (r.mask != 0) ? ST_TIMEOUT : ST_NONE;
      end
      FN_SYMBOL: p_sym[w.slot][w.pos] = w.button;
      FN_ATTR: begin
        p_tmo[w.slot] = w.ptime;
        p_en[w.slot] = w.pen;
      end
      FN_CLEAR: begin
        for (int c = 0; c < 4; c++)
          if (w.all || c == int'(w.channel)) begin
            h_len[c] = 0;
            h_tmr[c] = 0;
          end
      end
      default: r.status = ST_REJECT;
    endcase
    r.hist = h_len[w.channel];
    return r;
  endfunction

  task automatic send_word(press_word_t w, logic typed = 0, match_res_t given = '0);
    match_res_t r;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1;
    {func, channel, button, pressed, elapsed_ms, pattern_slot, position,
     pattern_timeout, pattern_enable, all_channels} <= w;
    do @(posedge clk); while (in_stall);
    r = predict_match(w);
    result_q.push_back(typed ? given : r);
    n_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      CFG_ENABLE: c_en = val[0];
      CFG_COUNT: c_cnt = val[4:0];
      default: c_dto = val;
    endcase
  endtask

  function automatic press_word_t mk(logic [2:0] f, logic [1:0] c, logic [3:0] b,
                                     logic p = 1);
    press_word_t w;
    w = '0;
    w.func = f;
    w.channel = c;
    w.button = b;
    w.pressed = p;
    return w;
  endfunction

  task automatic write_row(int s, int len);
    press_word_t w;
    for (int i = 0; i <= len && i < 16; i++) begin
      w = mk(FN_SYMBOL, 2'd0, (i == len) ? 4'd0 :
             ($urandom_range(4) == 0 ? WILDCARD : 4'($urandom_range(1, 8))));
      w.slot = 4'(s);
      w.pos = 4'(i);
      send_word(w);
    end
    w = mk(FN_ATTR, 2'd0, 4'd0);
    w.slot = 4'(s);
    w.pen = ($urandom_range(3) != 0);
    w.ptime = $urandom_range(1) ? 16'($urandom_range(50, 3000)) : 16'($urandom);
    send_word(w);
  endtask

  task automatic play_row(int s, int c);
    int len;
    logic [3:0] b;
    len = row_len(s);
    if (len > HIST_MAX) len = HIST_MAX;
    for (int i = 0; i < len; i++) begin
      b = (p_sym[s][i] == WILDCARD) ? 4'($urandom_range(1, 8)) : p_sym[s][i];
      if ($urandom_range(9) == 0) b = 4'($urandom_range(9));
      send_word(mk(FN_PRESS, 2'(c), b));
    end
  endtask

  task automatic random_word();
    press_word_t w;
    int pick;
    pick = $urandom_range(99);
    w = mk(FN_PRESS, 2'($urandom_range(3)), 4'($urandom_range(9)));
    w.delta = 16'($urandom);
    w.slot = 4'($urandom_range(15));
    w.pos = 4'($urandom_range(15));
    w.ptime = 16'($urandom);
    w.pen = 1'($urandom_range(1));
    w.all = 1'($urandom_range(1));
    if (pick < 45) begin
      play_row($urandom_range(15), $urandom_range(3));
      return;
    end else if (pick < 52) begin
      repeat ($urandom_range(10, 18))
        send_word(mk(FN_PRESS, w.channel, 4'($urandom_range(9))));
      return;
    end else if (pick < 70) begin
      w.func = FN_TICK;
      if ($urandom_range(9) < 7) w.delta = 16'($urandom_range(400));
    end else if (pick < 78) begin
      w.func = FN_SYMBOL;
    end else if (pick < 84) begin
      w.func = FN_ATTR;
      if ($urandom_range(1)) w.ptime = 16'($urandom_range(50, 3000));
    end else if (pick < 90) begin
      w.pressed = 0;
    end else if (pick < 95) begin
      w.func = 3'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
    end else begin
      w.func = FN_CLEAR;
    end
    send_word(w);
  endtask

  // func ch btn prs delta slot pos ptime pen all | typed | st mp hl tm
  dir_row_t dir_tab [22] = '{
    '{'{FN_PRESS, 2'd0, 4'd1, 1'b1, 16'd0, 4'd0, 4'd0, 16'd0, 1'b0, 1'b0}, 1'b1,
      '{ST_NONE, 4'd0, 4'd1, 4'd0}},
    '{'{FN_PRESS, 2'd0, 4'd9, 1'b0, 16'd0, 4'd0, 4'd0, 16'd0, 1'b0, 1'b0}, 1'b1,
      '{ST_REJECT, 4'd0, 4'd1, 4'd0}},
    '{'{FN_UNUSED_LO, 2'd0, 4'd0, 1'b1, 16'd0, 4'd0, 4'd0, 16'd0, 1'b0, 1'b0}, 1'b1,
      '{ST_REJECT, 4'd0, 4'd1, 4'd0}},
    '{'{FN_UNUSED_MID, 2'd3, 4'd0, 1'b1, 16'd0, 4'd0, 4'd0, 16'd0, 1'b0, 1'b0}, 1'b1,
      '{ST_REJECT, 4'd0, 4'd0, 4'd0}},
    '{'{FN_UNUSED_HI, 2'd2, 4'd0, 1'b1, 16'd0, 4'd0, 4'd0, 16'd0, 1'b0, 1'b0}, 1'b1,
      '{ST_REJECT, 4'd0, 4'd0, 4'd0}},
    '{'{FN_TICK, 2'd0, 4'd0, 1'b0, 16'hFFFF, 4'd0, 4'd0, 16'd0, 1'b0, 1'b0}, 1'b1,
      '{ST_TIMEOUT, 4'd0, 4'd0, 4'd1}},
    '{'{FN_SYMBOL, 2'd0, 4'd1, 1'b0, 16'd0, 4'd0, 4'd0, 16'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{FN_SYMBOL, 2'd0, 4'd9, 1'b0, 16'd0, 4'd0, 4'd1, 16'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{FN_SYMBOL, 2'd0, 4'd8, 1'b0, 16'd0, 4'd0, 4'd2, 16'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{FN_ATTR, 2'd0, 4'd0, 1'b0, 16'd0, 4'd0, 4'd0, 16'hFFFF, 1'b1, 1'b0}, 1'b0, '0},
    '{'{FN_SYMBOL, 2'd0, 4'd9, 1'b0, 16'd0, 4'd15, 4'd15, 16'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{FN_ATTR, 2'd0, 4'd0, 1'b0, 16'd0, 4'd15, 4'd0, 16'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{FN_PRESS, 2'd1, 4'd1, 1'b1, 16'd0, 4'd0, 4'd0, 16'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{FN_PRESS, 2'd1, 4'd4, 1'b1, 16'd0, 4'd0, 4'd0, 16'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{FN_PRESS, 2'd1, 4'd8, 1'b1, 16'd0, 4'd0, 4'd0, 16'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{FN_PRESS, 2'd2, 4'd0, 1'b1, 16'd0, 4'd0, 4'd0, 16'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{FN_TICK, 2'd2, 4'd0, 1'b0, 16'd0, 4'd0, 4'd0, 16'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{FN_TICK, 2'd2, 4'd0, 1'b0, 16'd40000, 4'd0, 4'd0, 16'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{FN_TICK, 2'd2, 4'd0, 1'b0, 16'd40000, 4'd0, 4'd0, 16'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{FN_PRESS, 2'd3, 4'd2, 1'b1, 16'd0, 4'd0, 4'd0, 16'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{FN_CLEAR, 2'd3, 4'd0, 1'b0, 16'd0, 4'd0, 4'd0, 16'd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{FN_CLEAR, 2'd1, 4'd0, 1'b0, 16'd0, 4'd0, 4'd0, 16'd0, 1'b0, 1'b1}, 1'b0, '0}
  };

  logic        set_en  [8] = '{1, 1, 0, 1, 1, 1, 1, 1};
  logic [4:0]  set_cnt [8] = '{16, 31, 5, 0, 3, 16, 8, 31};
  logic [15:0] set_dto [8] = '{1000, 200, 0, 65535, 50, 0, 400, 1000};

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    match_res_t e;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= STALL_LIM) begin
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIM);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
      if (out_valid && !out_stall) begin
        n_seen++;
        if (status == ST_DETECT) n_detect++;
        if (status == ST_TIMEOUT) n_tmo++;
        if (result_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word status=%0d", $time, status);
        end else begin
          e = result_q.pop_front();
          if ({status, matched_pattern, history_length, timeout_mask} != e) begin
            errors++;
            $display("%0t: exp st=%0d mp=%0d hl=%0d tm=%h got st=%0d mp=%0d hl=%0d tm=%h",
                     $time, e.status, e.matched, e.hist, e.mask,
                     status, matched_pattern, history_length, timeout_mask);
          end
        end
      end
    end
  end

  initial begin
    int mark;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    write_reg(CFG_COUNT, 16'd31);
    foreach (dir_tab[i]) send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].r);
    for (int p = 0; p < 8; p++) begin
      wait_drained();
      idle_pct  = (p % 4 == 1) ? 60 : (p % 4 == 3) ? 20 : 0;
      stall_pct = (p % 4 == 2) ? 60 : (p % 4 == 3) ? 20 : 0;
      write_reg(CFG_ENABLE, {15'd0, set_en[p]});
      write_reg(CFG_COUNT, {11'd0, set_cnt[p]});
      write_reg(CFG_TIMEOUT, set_dto[p]);
      mark = n_sent;
      for (int s = 0; s < 5; s++)
        write_row($urandom_range(15), (s == 0 && p % 3 == 0) ? 15 : $urandom_range(1, 4));
      while (n_sent < mark + PHASE_WORDS) random_word();
    end
    in_valid <= 0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display("Sent %0d words, checked %0d results: %0d combos, %0d timeout ticks.",
             n_sent, n_seen, n_detect, n_tmo);
    $display("Eight phases across register settings and idle/stall mixes, %0d errors.",
             errors);
    if (errors == 0 && result_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

>>> sim.f
hw/rtl/bsm_pkg.sv
hw/rtl/bsm_ram.sv
hw/rtl/bsm_front.sv
hw/rtl/bsm_back.sv
hw/rtl/button_sequence_matcher_unit.sv
tb/sv/button_sequence_matcher_unit_tb.sv
